FILE: sv/bce_pkg.sv
// types and constants shared by the binomial coefficient engine
// no dependencies; compile first

package bce_pkg;

    localparam int N_W       = 64;             // width of n and of the result
    localparam int K_W       = 6;              // width of k
    localparam int D_W       = K_W + 1;        // step counter, holds k + 1
    localparam int MAX_K     = 63;             // largest k accepted
    localparam int DIG_W     = 8;              // divider / multiplier digit
    localparam int NDIG      = N_W / DIG_W;
    localparam int DIG_CNT_W = $clog2(NDIG);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EUC_TEST,
        ST_EUC_WAIT,
        ST_Q_START,
        ST_Q_WAIT,
        ST_R_START,
        ST_R_WAIT,
        ST_T_START,
        ST_T_WAIT,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_FINISH
    } state_t;

    // which division the shared divider is doing
    typedef enum logic [1:0] {
        DIV_EUC,    // a % b in the gcd loop
        DIV_Q,      // d / g
        DIV_R,      // r / g
        DIV_T       // m / q
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     euc_init;
        logic     div_start;
        logic     div_cap;
        div_sel_t div_sel;
        logic     mul_start;
        logic     mul_cap;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic special;      // result already known (k > n, k too big, overflow)
        logic d_gt_k;       // all steps done
        logic b_zero;       // gcd loop finished
        logic div_done;
        logic mul_done;
        logic out_free;     // output register can take a word
    } dp_stat_t;

endpackage

FILE: sv/bce_if.sv
// request and response channels of the binomial coefficient engine
// depends on bce_pkg

interface bce_req_if;
    import bce_pkg::*;

    logic           valid;
    logic           ready;
    logic [N_W-1:0] n_value;
    logic [K_W-1:0] k_count;

    modport source (output valid, output n_value, output k_count, input ready);
    modport sink   (input valid, input n_value, input k_count, output ready);
endinterface

interface bce_rsp_if;
    import bce_pkg::*;

    logic           valid;
    logic           ready;
    logic [N_W-1:0] coefficient;
    logic           overflow;

    modport source (output valid, output coefficient, output overflow, input ready);
    modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

FILE: sv/bce_div.sv
// shared divider: 64-bit dividend by 6-bit divisor, one byte of quotient per cycle
// leading zero bytes of the dividend are skipped; depends on bce_pkg

module bce_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [bce_pkg::N_W-1:0] dividend,
    input  logic [bce_pkg::K_W-1:0] divisor,
    output logic                    done,
    output logic [bce_pkg::N_W-1:0] quotient,
    output logic [bce_pkg::K_W-1:0] remainder
);
    import bce_pkg::*;

    logic [N_W-1:0]       quo_reg, quo_next;
    logic [K_W-1:0]       rem_reg, rem_next;
    logic [DIG_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIG_CNT_W-1:0] top_byte;
    logic [DIG_CNT_W-1:0] shamt;
    logic [N_W-1:0]       step_quo;
    logic [K_W-1:0]       step_rem;

    // highest nonzero byte of the dividend
    always_comb
    begin
        top_byte = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (dividend[i*DIG_W +: DIG_W] != '0)
            begin
                top_byte = DIG_CNT_W'(i);
            end
        end
        shamt = DIG_CNT_W'(NDIG - 1) - top_byte;
    end

    // one byte of restoring division
    always_comb
    begin
        logic [K_W:0]   ext;
        logic [N_W-1:0] w;
        logic [K_W-1:0] r;
        w = quo_reg;
        r = rem_reg;
        for (int j = 0; j < DIG_W; j++)
        begin
            ext = {r, w[N_W-1]};
            w   = {w[N_W-2:0], 1'b0};
            if (ext >= {1'b0, divisor})
            begin
                ext  = ext - {1'b0, divisor};
                w[0] = 1'b1;
            end
            r = ext[K_W-1:0];
        end
        step_quo = w;
        step_rem = r;
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend << (shamt * DIG_W);
            rem_next  = '0;
            cnt_next  = top_byte;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = step_quo;
            rem_next = step_rem;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/bce_mul.sv
// 64 x 64 multiplier, one byte of the multiplier per cycle, msb byte first
// flags any product that leaves 64 bits; depends on bce_pkg

module bce_mul (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [bce_pkg::N_W-1:0] multiplicand,
    input  logic [bce_pkg::N_W-1:0] multiplier,
    output logic                    done,
    output logic [bce_pkg::N_W-1:0] product,
    output logic                    ovf
);
    import bce_pkg::*;

    logic [N_W-1:0]       acc_reg, acc_next;
    logic [N_W-1:0]       mcd_reg, mcd_next;
    logic [N_W-1:0]       mpr_reg, mpr_next;
    logic [DIG_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ovf_reg, ovf_next;

    logic [DIG_W-1:0]       digit;
    logic [N_W+DIG_W-1:0]   pp;
    logic [N_W+DIG_W:0]     sum;

    assign digit = mpr_reg[N_W-1 -: DIG_W];
    assign pp    = {{DIG_W{1'b0}}, mcd_reg} * {{N_W{1'b0}}, digit};
    // acc * 256 + multiplicand * digit, top byte of acc checked separately
    assign sum   = {{(DIG_W+1){1'b0}}, acc_reg[N_W-DIG_W-1:0], {DIG_W{1'b0}}}
                 + {1'b0, pp};

    always_comb
    begin
        acc_next  = acc_reg;
        mcd_next  = mcd_reg;
        mpr_next  = mpr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mcd_next  = multiplicand;
            mpr_next  = multiplier;
            cnt_next  = DIG_CNT_W'(NDIG - 1);
            busy_next = 1'b1;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            acc_next = sum[N_W-1:0];
            mpr_next = mpr_reg << DIG_W;
            ovf_next = ovf_reg || (acc_reg[N_W-1 -: DIG_W] != '0)
                     || (sum[N_W+DIG_W:N_W] != '0);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcd_reg <= mcd_next;
        mpr_reg <= mpr_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
    assign ovf     = ovf_reg;

endmodule

FILE: sv/bce_dp.sv
// datapath: running product, gcd loop registers, shared divider, multiplier,
// output register; depends on bce_pkg, bce_if, bce_div, bce_mul

module bce_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  bce_pkg::ctrl_cmd_t  cmd,
    output bce_pkg::dp_stat_t   stat,
    input  logic [bce_pkg::N_W-1:0] n_value,
    input  logic [bce_pkg::K_W-1:0] k_count,
    bce_rsp_if.source           rsp
);
    import bce_pkg::*;

    logic [N_W-1:0] r_reg, r_next;
    logic [N_W-1:0] m_reg, m_next;
    logic [N_W-1:0] a_reg, a_next;
    logic [N_W-1:0] t_reg, t_next;
    logic [K_W-1:0] b_reg, b_next;
    logic [K_W-1:0] q_reg, q_next;
    logic [K_W-1:0] k_reg, k_next;
    logic [D_W-1:0] d_reg, d_next;
    logic           zero_reg, zero_next;
    logic           ovf_reg, ovf_next;
    logic [N_W-1:0] coef_reg, coef_next;
    logic           oflag_reg, oflag_next;
    logic           ovalid_reg, ovalid_next;

    logic [N_W-1:0] div_dividend;
    logic [K_W-1:0] div_divisor;
    logic           div_done;
    logic [N_W-1:0] div_quo;
    logic [K_W-1:0] div_rem;
    logic           mul_done;
    logic [N_W-1:0] mul_prod;
    logic           mul_ovf;
    logic [K_W-1:0] g;
    logic           k_gt_n;

    // gcd sits in a once the remainder loop has ended
    assign g      = a_reg[K_W-1:0];
    assign k_gt_n = {{(N_W-K_W){1'b0}}, k_count} > n_value;

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_EUC:
            begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
            DIV_Q:
            begin
                div_dividend = {{(N_W-K_W){1'b0}}, d_reg[K_W-1:0]};
                div_divisor  = g;
            end
            DIV_R:
            begin
                div_dividend = r_reg;
                div_divisor  = g;
            end
            DIV_T:
            begin
                div_dividend = m_reg;
                div_divisor  = q_reg;
            end
        endcase
    end

    bce_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    bce_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd.mul_start),
        .multiplicand (r_reg),
        .multiplier   (t_reg),
        .done         (mul_done),
        .product      (mul_prod),
        .ovf          (mul_ovf)
    );

    always_comb
    begin
        r_next      = r_reg;
        m_next      = m_reg;
        a_next      = a_reg;
        t_next      = t_reg;
        b_next      = b_reg;
        q_next      = q_reg;
        k_next      = k_reg;
        d_next      = d_reg;
        zero_next   = zero_reg;
        ovf_next    = ovf_reg;
        coef_next   = coef_reg;
        oflag_next  = oflag_reg;
        ovalid_next = ovalid_reg && !rsp.ready;

        if (cmd.load)
        begin
            k_next    = k_count;
            m_next    = n_value;
            r_next    = N_W'(1);
            d_next    = D_W'(1);
            zero_next = k_gt_n;
            ovf_next  = !k_gt_n && (int'(k_count) > MAX_K);
        end
        if (cmd.euc_init)
        begin
            a_next = r_reg;
            b_next = d_reg[K_W-1:0];
        end
        if (cmd.div_cap)
        begin
            unique case (cmd.div_sel)
                DIV_EUC:
                begin
                    a_next = {{(N_W-K_W){1'b0}}, b_reg};
                    b_next = div_rem;
                end
                DIV_Q: q_next = div_quo[K_W-1:0];
                DIV_R: r_next = div_quo;
                DIV_T: t_next = div_quo;
            endcase
        end
        if (cmd.mul_cap)
        begin
            if (mul_ovf)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                r_next = mul_prod;
                m_next = m_reg - 1'b1;
                d_next = d_reg + 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
            oflag_next  = ovf_reg && !zero_reg;
            if (zero_reg)
            begin
                coef_next = '0;
            end
            else if (ovf_reg)
            begin
                coef_next = '1;
            end
            else
            begin
                coef_next = r_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            zero_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            d_reg      <= '0;
            k_reg      <= '0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            zero_reg   <= zero_next;
            ovf_reg    <= ovf_next;
            d_reg      <= d_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        m_reg     <= m_next;
        a_reg     <= a_next;
        t_reg     <= t_next;
        b_reg     <= b_next;
        q_reg     <= q_next;
        coef_reg  <= coef_next;
        oflag_reg <= oflag_next;
    end

    assign stat.special  = zero_reg || ovf_reg;
    assign stat.d_gt_k   = d_reg > {1'b0, k_reg};
    assign stat.b_zero   = (b_reg == '0);
    assign stat.div_done = div_done;
    assign stat.mul_done = mul_done;
    assign stat.out_free = !ovalid_reg || rsp.ready;

    assign rsp.valid       = ovalid_reg;
    assign rsp.coefficient = coef_reg;
    assign rsp.overflow    = oflag_reg;

endmodule

FILE: sv/bce_ctrl.sv
// controller: sequences the gcd loop, the three divisions and the multiply
// for each step d; depends on bce_pkg

module bce_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bce_pkg::dp_stat_t  stat,
    output bce_pkg::ctrl_cmd_t cmd
);
    import bce_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.special || stat.d_gt_k)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_EUC_TEST;
                end
            end
            ST_EUC_TEST:
            begin
                if (stat.b_zero)
                begin
                    state_next = ST_Q_START;
                end
                else
                begin
                    state_next = ST_EUC_WAIT;
                end
            end
            ST_EUC_WAIT:  if (stat.div_done) state_next = ST_EUC_TEST;
            ST_Q_START:   state_next = ST_Q_WAIT;
            ST_Q_WAIT:    if (stat.div_done) state_next = ST_R_START;
            ST_R_START:   state_next = ST_R_WAIT;
            ST_R_WAIT:    if (stat.div_done) state_next = ST_T_START;
            ST_T_START:   state_next = ST_T_WAIT;
            ST_T_WAIT:    if (stat.div_done) state_next = ST_MUL_START;
            ST_MUL_START: state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:  if (stat.mul_done) state_next = ST_CHECK;
            ST_FINISH:    if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.div_sel = DIV_EUC;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK:
            begin
                cmd.euc_init = !(stat.special || stat.d_gt_k);
            end
            ST_EUC_TEST:
            begin
                cmd.div_start = !stat.b_zero;
            end
            ST_EUC_WAIT:
            begin
                cmd.div_cap = stat.div_done;
            end
            ST_Q_START:
            begin
                cmd.div_sel   = DIV_Q;
                cmd.div_start = 1'b1;
            end
            ST_Q_WAIT:
            begin
                cmd.div_sel = DIV_Q;
                cmd.div_cap = stat.div_done;
            end
            ST_R_START:
            begin
                cmd.div_sel   = DIV_R;
                cmd.div_start = 1'b1;
            end
            ST_R_WAIT:
            begin
                cmd.div_sel = DIV_R;
                cmd.div_cap = stat.div_done;
            end
            ST_T_START:
            begin
                cmd.div_sel   = DIV_T;
                cmd.div_start = 1'b1;
            end
            ST_T_WAIT:
            begin
                cmd.div_sel = DIV_T;
                cmd.div_cap = stat.div_done;
            end
            ST_MUL_START:
            begin
                cmd.mul_start = 1'b1;
            end
            ST_MUL_WAIT:
            begin
                cmd.mul_cap = stat.mul_done;
            end
            ST_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/binomial_coefficient_engine.sv
// Binomial coefficient engine: takes n (64 bits) and k (6 bits) on req and returns
// C(n,k) on rsp, with overflow set and the coefficient all ones when an intermediate
// product leaves 64 bits; k greater than n gives 0. One request is worked at a time:
// a request is taken only while the engine is idle, but a finished word may wait in
// the output register while the next request is taken. Each step d = 1..k runs
// Euclid's remainder loop for gcd(r,d) and three divisions on one shared divider
// that retires one byte of quotient per cycle (skipping leading zero bytes), then a
// byte-serial multiplier. The time a step takes depends on operand sizes and the
// length of the remainder loop, and a request may also wait for the output register
// to free up.
// Depends on bce_pkg, bce_if, bce_ctrl and bce_dp.

module binomial_coefficient_engine (
    input  logic      clk,
    input  logic      rst_n,
    bce_req_if.sink   req,
    bce_rsp_if.source rsp
);
    import bce_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    bce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bce_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .n_value (req.n_value),
        .k_count (req.k_count),
        .rsp     (rsp)
    );

endmodule

FILE: sv/bce_chk.sv
// port-level checks of the binomial coefficient engine, bound to the top level
// depends on bce_pkg and binomial_coefficient_engine

module bce_chk (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic [bce_pkg::N_W-1:0] coefficient,
    input logic                    overflow
);
    import bce_pkg::*;

    // a stalled word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(coefficient) && $stable(overflow))
        else $error("response word changed while stalled");

    // overflow always comes with a saturated coefficient
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && overflow |-> coefficient == {N_W{1'b1}})
        else $error("overflow without saturated coefficient");

    // engine is busy the cycle after it takes a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a computation is starting");

    // a new word only appears from the finishing state, never while idle
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response appeared without a finished computation");

endmodule

bind binomial_coefficient_engine bce_chk u_bce_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .coefficient (rsp.coefficient),
    .overflow    (rsp.overflow)
);

FILE: sim/tb_top.sv
// testbench for the binomial coefficient engine: a directed table, then random requests
// checked against a running-product predictor of C(n,k) with overflow saturation
// depends on bce_pkg, bce_if and binomial_coefficient_engine

`timescale 1ns / 1ps

module tb_top;
    import bce_pkg::*;

    localparam logic [N_W-1:0] ALL_ONES     = {N_W{1'b1}};
    localparam int             N_DIRECTED   = 24;
    localparam int             RAND_PER_PHASE = 100;
    localparam int             HOLD_CYCLES  = 3000;
    localparam int             DRAIN_CYCLES = 200;
    localparam int             LIMIT_CYCLES = 8000000;

    typedef struct packed {
        logic [N_W-1:0] coefficient;
        logic           overflow;
    } binom_t;

    typedef struct packed {
        logic [N_W-1:0] n_value;
        logic [K_W-1:0] k_count;
        binom_t         result;
    } pending_word_t;

    // typed = 1: expected result is given in the row, else it comes from the predictor
    typedef struct packed {
        logic [N_W-1:0] n_value;
        logic [K_W-1:0] k_count;
        logic           typed;
        logic [N_W-1:0] coefficient;
        logic           overflow;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bce_req_if req_ch ();
    bce_rsp_if rsp_ch ();

    binomial_coefficient_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pending_word_t pending_coefs [$];
    stim_row_t     directed_rows [N_DIRECTED];

    int mismatch_count = 0;
    int words_checked  = 0;
    int saturated_seen = 0;
    int zero_seen      = 0;
    int random_sent    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int rsp_idle_pct   = 0;
    int hold_left      = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // running product: r = C(n,d) after step d, divided by gcd first so it stays exact
    function automatic binom_t predict_binomial(input logic [N_W-1:0] n,
                                                input logic [K_W-1:0] k);
        logic [N_W-1:0] r;
        logic [N_W-1:0] m;
        logic [N_W-1:0] a;
        logic [N_W-1:0] b;
        logic [N_W-1:0] rem;
        logic [N_W-1:0] g;
        logic [N_W-1:0] q;
        logic [N_W-1:0] t;
        binom_t         res;
        res.coefficient = '0;
        res.overflow    = 1'b0;
        if (N_W'(k) > n)
            return res;
        if (int'(k) > MAX_K)
        begin
            res.coefficient = ALL_ONES;
            res.overflow    = 1'b1;
            return res;
        end
        r = N_W'(1);
        m = n;
        for (int d = 1; d <= int'(k); d++)
        begin
            a = r;
            b = N_W'(d);
            while (b != 0)
            begin
                rem = a % b;
                a   = b;
                b   = rem;
            end
            g = a;
            q = N_W'(d) / g;
            r = r / g;
            t = m / q;
            if (r != 0 && t > ALL_ONES / r)
            begin
                res.coefficient = ALL_ONES;
                res.overflow    = 1'b1;
                return res;
            end
            r = r * t;
            m = m - 1;
        end
        res.coefficient = r;
        return res;
    endfunction

    function automatic logic [N_W-1:0] random_wide(input int bits);
        logic [N_W-1:0] v;
        v = {$urandom, $urandom};
        if (bits < N_W)
            v = v >> (N_W - bits);
        return v;
    endfunction

    // mostly small n with any k, or wide n with small k so runs stay short
    task automatic pick_request(output logic [N_W-1:0] n, output logic [K_W-1:0] k);
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            n = N_W'($urandom_range(80));
            k = K_W'($urandom_range(63));
        end
        else if (sel < 80)
        begin
            n = random_wide($urandom_range(1, N_W));
            k = K_W'($urandom_range(8));
        end
        else if (sel < 90)
        begin
            n = random_wide(N_W);
            k = K_W'($urandom_range(63));
        end
        else
        begin
            if ($urandom_range(1))
                n = ALL_ONES - N_W'($urandom_range(3));
            else
                n = (N_W'(1) << $urandom_range(N_W - 1)) + N_W'($urandom_range(2)) - 1;
            k = K_W'($urandom_range(4));
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // called at a rising edge; returns at the edge where the word was taken
    task automatic send_request(input logic [N_W-1:0] n, input logic [K_W-1:0] k,
                                input binom_t expected);
        pending_word_t pw;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.n_value <= n;
        req_ch.k_count <= k;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pw.n_value = n;
        pw.k_count = k;
        pw.result  = expected;
        pending_coefs = {pending_coefs, pw};
    endtask

    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        while (pending_coefs.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random ready, or held low while hold_left counts down
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        pending_word_t pw;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_coefs.size() == 0)
                report_mismatch($sformatf("unexpected word coef=%h ovf=%b",
                                          rsp_ch.coefficient, rsp_ch.overflow));
            else
            begin
                pw = pending_coefs.pop_front();
                words_checked++;
                if (pw.result.overflow)
                    saturated_seen++;
                else if (pw.result.coefficient == 0)
                    zero_seen++;
                if (rsp_ch.coefficient !== pw.result.coefficient)
                    report_mismatch($sformatf("n=%h k=%0d coefficient %h, expected %h",
                                              pw.n_value, pw.k_count, rsp_ch.coefficient,
                                              pw.result.coefficient));
                if (rsp_ch.overflow !== pw.result.overflow)
                    report_mismatch($sformatf("n=%h k=%0d overflow %b, expected %b",
                                              pw.n_value, pw.k_count, rsp_ch.overflow,
                                              pw.result.overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_coefs.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [N_W-1:0] n;
        logic [K_W-1:0] k;
        binom_t         expected;

        rst_n          = 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.n_value <= '0;
        req_ch.k_count <= '0;

        directed_rows = '{
            '{N_W'(0),          K_W'(0),  1'b1, N_W'(1),          1'b0},
            '{N_W'(0),          K_W'(1),  1'b1, N_W'(0),          1'b0},
            '{N_W'(5),          K_W'(63), 1'b1, N_W'(0),          1'b0},
            '{N_W'(62),         K_W'(63), 1'b1, N_W'(0),          1'b0},
            '{N_W'(63),         K_W'(63), 1'b1, N_W'(1),          1'b0},
            '{N_W'(7),          K_W'(7),  1'b1, N_W'(1),          1'b0},
            '{N_W'(3),          K_W'(0),  1'b1, N_W'(1),          1'b0},
            '{N_W'(1),          K_W'(1),  1'b1, N_W'(1),          1'b0},
            '{N_W'(10),         K_W'(5),  1'b1, N_W'(252),        1'b0},
            '{ALL_ONES,         K_W'(0),  1'b1, N_W'(1),          1'b0},
            '{ALL_ONES,         K_W'(1),  1'b1, ALL_ONES,         1'b0},
            '{ALL_ONES,         K_W'(2),  1'b1, ALL_ONES,         1'b1},
            '{ALL_ONES,         K_W'(63), 1'b1, ALL_ONES,         1'b1},
            '{{32{2'b10}},      K_W'(1),  1'b1, {32{2'b10}},      1'b0},
            '{{32{2'b01}},      K_W'(1),  1'b1, {32{2'b01}},      1'b0},
            '{N_W'(63),         K_W'(62), 1'b0, N_W'(0),          1'b0},
            '{N_W'(64),         K_W'(32), 1'b0, N_W'(0),          1'b0},
            '{N_W'(67),         K_W'(33), 1'b0, N_W'(0),          1'b0},
            '{N_W'(68),         K_W'(34), 1'b0, N_W'(0),          1'b0},
            '{N_W'(100),        K_W'(50), 1'b0, N_W'(0),          1'b0},
            '{N_W'(1000),       K_W'(10), 1'b0, N_W'(0),          1'b0},
            '{N_W'(1) << 63,    K_W'(2),  1'b0, N_W'(0),          1'b0},
            '{N_W'(1) << 32,    K_W'(2),  1'b0, N_W'(0),          1'b0},
            '{(N_W'(1) << 32) + 1, K_W'(3), 1'b0, N_W'(0),        1'b0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22;
        rsp_idle_pct  = 74;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].typed)
            begin
                expected.coefficient = directed_rows[i].coefficient;
                expected.overflow    = directed_rows[i].overflow;
            end
            else
                expected = predict_binomial(directed_rows[i].n_value,
                                            directed_rows[i].k_count);
            send_request(directed_rows[i].n_value, directed_rows[i].k_count, expected);
        end
        // sender pauses here until every word is back
        wait_all_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 22;
                    rsp_idle_pct  = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    rsp_idle_pct  = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rsp_idle_pct  = 0;
                end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                // long receiver hold-off while requests keep coming, fills the output stage
                if (phase == 2 && i == 20 && hold_left == 0)
                    hold_left = HOLD_CYCLES;
                pick_request(n, k);
                send_request(n, k, predict_binomial(n, k));
                random_sent++;
            end
            wait_all_results();
        end

        rsp_idle_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_coefs.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", pending_coefs.size()));

        $display("covered %0d table rows and %0d random requests, %0d words checked",
                 N_DIRECTED, random_sent, words_checked);
        $display("%0d saturated on overflow, %0d zero with k above n, %0d cycles",
                 saturated_seen, zero_seen, cycle_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
sv/bce_pkg.sv
sv/bce_if.sv
sv/bce_div.sv
sv/bce_mul.sv
sv/bce_dp.sv
sv/bce_ctrl.sv
sv/binomial_coefficient_engine.sv
sv/bce_chk.sv
sim/tb_top.sv
